// ----- rtl/core/lcbs_pkg.sv -----
`default_nettype none

package lcbs_pkg;

	localparam int LCBS_MAX_SEGMENTS = 64;
	localparam int LCBS_MAX_BITS     = 6144;
	localparam int LCBS_CRC_BITS     = 24;
	localparam int LCBS_SEG_PAYLOAD  = LCBS_MAX_BITS - LCBS_CRC_BITS;
	localparam int LCBS_MIN_SIZE     = 40;

	// ceil(x/6120) = floor(floor((x+6119)/8)/765); 765*21931 = 2^24-1
	localparam int LCBS_PAYLOAD_DIV8 = LCBS_SEG_PAYLOAD / 8;
	localparam int LCBS_RECIP_SHIFT  = 24;
	localparam int LCBS_RECIP        = ((1 << LCBS_RECIP_SHIFT) - 1) / LCBS_PAYLOAD_DIV8;

	localparam int LCBS_B_W    = 19;
	localparam int LCBS_BP_W   = 20;
	localparam int LCBS_C_W    = 7;
	localparam int LCBS_K_W    = 13;
	localparam int LCBS_F_W    = 6;
	localparam int LCBS_SH_W   = 3;

	localparam int LCBS_DIV_STAGES = LCBS_K_W;
	localparam int LCBS_FIFO_DEPTH = 4;
	localparam int LCBS_PTR_W      = $clog2(LCBS_FIFO_DEPTH);
	localparam int LCBS_CNT_W      = $clog2(LCBS_FIFO_DEPTH + 1);

	localparam int LCBS_IN_TDATA_W  = 24;
	localparam int LCBS_OUT_TDATA_W = 56;

	localparam logic LCBS_STATUS_OK  = 1'b0;
	localparam logic LCBS_STATUS_ERR = 1'b1;

	typedef struct packed {
		logic                 status;
		logic [LCBS_C_W-1:0]  num_seg;
		logic [LCBS_BP_W-1:0] bp;
		logic [LCBS_BP_W-1:0] num;
	} lcbs_job_t;

	typedef struct packed {
		logic                 status;
		logic [LCBS_C_W-1:0]  num_seg;
		logic [LCBS_BP_W-1:0] bp;
		logic [LCBS_BP_W-1:0] rem;
		logic [LCBS_K_W-1:0]  quo;
	} lcbs_div_t;

	typedef struct packed {
		logic                 status;
		logic [LCBS_C_W-1:0]  num_seg;
		logic [LCBS_BP_W-1:0] bp;
		logic [LCBS_K_W-1:0]  kp;
		logic [LCBS_SH_W-1:0] sh;
	} lcbs_fin_t;

	typedef struct packed {
		logic                status;
		logic [LCBS_C_W-1:0] num_segments;
		logic [LCBS_C_W-1:0] num_plus;
		logic [LCBS_C_W-1:0] num_minus;
		logic [LCBS_K_W-1:0] size_plus;
		logic [LCBS_K_W-1:0] size_minus;
		logic [LCBS_F_W-1:0] filler_bits;
	} lcbs_res_t;

	// log2 of the interleaver grid step at size k
	function automatic logic [LCBS_SH_W-1:0] lcbs_grid_shift(input logic [LCBS_K_W:0] k);
		logic [LCBS_SH_W-1:0] sh;
		if (k <= (LCBS_K_W+1)'(512))
			sh = LCBS_SH_W'(3);
		else if (k <= (LCBS_K_W+1)'(1024))
			sh = LCBS_SH_W'(4);
		else if (k <= (LCBS_K_W+1)'(2048))
			sh = LCBS_SH_W'(5);
		else
			sh = LCBS_SH_W'(6);
		return sh;
	endfunction

	function automatic logic [LCBS_K_W:0] lcbs_round_grid(input logic [LCBS_K_W-1:0] q);
		logic [LCBS_K_W:0]    qx;
		logic [LCBS_K_W:0]    step;
		logic [LCBS_K_W:0]    kp;
		qx = {1'b0, q};
		if (qx <= (LCBS_K_W+1)'(LCBS_MIN_SIZE)) begin
			kp = (LCBS_K_W+1)'(LCBS_MIN_SIZE);
		end else begin
			step = (LCBS_K_W+1)'(1) << lcbs_grid_shift(qx);
			kp   = (qx + step - (LCBS_K_W+1)'(1)) & ~(step - (LCBS_K_W+1)'(1));
		end
		return kp;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/lcbs_front.sv -----
`default_nettype none

module lcbs_front import lcbs_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [LCBS_B_W-1:0] tb_size,
	output logic                     push,
	output lcbs_job_t                push_job,
	input  wire logic                full
);

	logic                valid_s1, valid_s2;
	logic [LCBS_B_W-1:0] b_s1, b_s2;
	logic [16:0]         y_s1;
	logic [LCBS_C_W-1:0] qe_s1;
	logic [LCBS_C_W-1:0] c_s2;

	logic                adv;
	logic [LCBS_B_W:0]   x;
	logic [16:0]         y;
	logic [31:0]         prod;
	logic [16:0]         r;
	logic [LCBS_C_W-1:0] c_next;

	assign adv      = ~valid_s2 | ~full;
	assign in_ready = adv;

	always_comb begin
		x    = {1'b0, tb_size} + (LCBS_B_W+1)'(LCBS_SEG_PAYLOAD - 1);
		y    = x[LCBS_B_W:3];
		prod = 32'(y) * 32'(LCBS_RECIP);
	end

	always_comb begin
		r      = y_s1 - 17'(qe_s1) * 17'(LCBS_PAYLOAD_DIV8);
		c_next = qe_s1 + LCBS_C_W'(r >= 17'(LCBS_PAYLOAD_DIV8));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b_s1  <= tb_size;
			y_s1  <= y;
			qe_s1 <= prod[LCBS_RECIP_SHIFT +: LCBS_C_W];
			b_s2  <= b_s1;
			c_s2  <= c_next;
		end
	end

	// classify: single block, or C blocks with a CRC each
	always_comb begin
		logic                one_blk;
		logic [LCBS_C_W-1:0] c_eff;
		logic [LCBS_BP_W-1:0] bp;
		one_blk = b_s2 <= LCBS_B_W'(LCBS_MAX_BITS);
		c_eff = one_blk ? LCBS_C_W'(1) : c_s2;
		bp    = one_blk ? {1'b0, b_s2}
		                : {1'b0, b_s2} + LCBS_BP_W'(c_s2) * LCBS_BP_W'(LCBS_CRC_BITS);
		push_job.status  = (c_eff > LCBS_C_W'(LCBS_MAX_SEGMENTS)) ? LCBS_STATUS_ERR
		                                                          : LCBS_STATUS_OK;
		push_job.num_seg = c_eff;
		push_job.bp      = bp;
		push_job.num     = bp + LCBS_BP_W'(c_eff) - LCBS_BP_W'(1);
	end

	assign push = valid_s2 & ~full;

endmodule

`default_nettype wire

// ----- rtl/core/lcbs_fifo.sv -----
`default_nettype none

module lcbs_fifo import lcbs_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  lcbs_job_t      wr_data,
	output logic           full,
	input  wire logic      pop,
	output lcbs_job_t      rd_data,
	output logic           empty
);

	lcbs_job_t               mem_q [LCBS_FIFO_DEPTH];
	logic [LCBS_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [LCBS_CNT_W-1:0]   count_q;

	assign full    = count_q == LCBS_CNT_W'(LCBS_FIFO_DEPTH);
	assign empty   = count_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + LCBS_PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + LCBS_PTR_W'(1);
			count_q <= count_q + LCBS_CNT_W'(push) - LCBS_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("beat written into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("beat read from empty queue");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/lcbs_back.sv -----
`default_nettype none

module lcbs_back import lcbs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  lcbs_job_t job,
	input  wire logic empty,
	output logic      pop,
	output logic      out_valid,
	input  wire logic out_ready,
	output lcbs_res_t out_res
);

	localparam int LAST = LCBS_DIV_STAGES - 1;

	logic [LCBS_DIV_STAGES-1:0] div_valid_q;
	lcbs_div_t                  div_q [LCBS_DIV_STAGES];
	lcbs_div_t                  div_d [LCBS_DIV_STAGES];
	logic                       fin_valid_q;
	lcbs_fin_t                  fin_q;
	lcbs_fin_t                  fin_d;
	logic                       out_valid_q;
	lcbs_res_t                  out_q;
	lcbs_res_t                  out_d;
	logic                       adv;

	assign adv = ~out_valid_q | out_ready;
	assign pop = adv & ~empty;

	// restoring divider, one quotient bit per stage, MSB first
	always_comb begin
		lcbs_div_t          src;
		logic [LCBS_BP_W:0] dvs;
		for (int i = 0; i < LCBS_DIV_STAGES; i++) begin
			if (i == 0) begin
				src.status  = job.status;
				src.num_seg = job.num_seg;
				src.bp      = job.bp;
				src.rem     = job.num;
				src.quo     = '0;
			end else begin
				src = div_q[(i == 0) ? 0 : i - 1];
			end
			dvs = (LCBS_BP_W+1)'(src.num_seg) << (LAST - i);
			div_d[i] = src;
			if ({1'b0, src.rem} >= dvs) begin
				div_d[i].rem = src.rem - dvs[LCBS_BP_W-1:0];
				div_d[i].quo[LAST - i] = 1'b1;
			end
		end
	end

	always_comb begin
		logic [LCBS_K_W:0] kp;
		kp = lcbs_round_grid(div_q[LAST].quo);
		fin_d.status  = div_q[LAST].status;
		fin_d.num_seg = div_q[LAST].num_seg;
		fin_d.bp      = div_q[LAST].bp;
		fin_d.kp      = kp[LCBS_K_W-1:0];
		fin_d.sh      = lcbs_grid_shift(kp);
	end

	// d = C*K+ - B'; for C > 1, C- = d / step and F = d mod step; for C = 1, F = d
	always_comb begin
		logic [LCBS_BP_W-1:0] prod;
		logic [LCBS_BP_W-1:0] d;
		logic [LCBS_BP_W-1:0] cm;
		logic [LCBS_C_W-1:0]  mask;
		prod = LCBS_BP_W'(fin_q.num_seg) * LCBS_BP_W'(fin_q.kp);
		d    = prod - fin_q.bp;
		cm   = d >> fin_q.sh;
		mask = (LCBS_C_W'(1) << fin_q.sh) - LCBS_C_W'(1);
		out_d = '0;
		if (fin_q.status == LCBS_STATUS_ERR) begin
			out_d.status = LCBS_STATUS_ERR;
		end else if (fin_q.num_seg == LCBS_C_W'(1)) begin
			out_d.num_segments = fin_q.num_seg;
			out_d.num_plus     = LCBS_C_W'(1);
			out_d.size_plus    = fin_q.kp;
			out_d.filler_bits  = d[LCBS_F_W-1:0];
		end else begin
			out_d.num_segments = fin_q.num_seg;
			out_d.num_minus    = cm[LCBS_C_W-1:0];
			out_d.num_plus     = fin_q.num_seg - cm[LCBS_C_W-1:0];
			out_d.size_plus    = fin_q.kp;
			out_d.size_minus   = fin_q.kp - (LCBS_K_W'(1) << fin_q.sh);
			out_d.filler_bits  = d[LCBS_F_W-1:0] & mask[LCBS_F_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_valid_q <= '0;
			fin_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			div_valid_q <= {div_valid_q[LCBS_DIV_STAGES-2:0], ~empty};
			fin_valid_q <= div_valid_q[LAST];
			out_valid_q <= fin_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < LCBS_DIV_STAGES; i++)
				div_q[i] <= div_d[i];
			fin_q <= fin_d;
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

`ifndef SYNTHESIS
	a_counts_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == LCBS_STATUS_OK) |->
		(out_q.num_plus + out_q.num_minus == out_q.num_segments))
		else $error("block counts do not add up");
	a_size_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == LCBS_STATUS_OK) |->
		(out_q.size_plus >= LCBS_K_W'(LCBS_MIN_SIZE) &&
		 out_q.size_plus <= LCBS_K_W'(LCBS_MAX_BITS) && out_q.num_segments != '0))
		else $error("K+ outside interleaver range");
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == LCBS_STATUS_ERR) |->
		(out_q.num_segments == '0 && out_q.size_plus == '0 && out_q.filler_bits == '0))
		else $error("error result carries data");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/lte_code_block_segmentation.sv -----
`default_nettype none

// LTE turbo code block segmentation (36.212 5.1.2). One transport block size
// per s_axis beat, one result per m_axis beat, in order. Throughput is one beat
// per cycle while m_axis_tready stays high. A size passes two front stages that
// find the segment count C by a reciprocal multiply, the 4-entry queue, 13
// stages of a pipelined restoring divider for ceil(B'/C), one grid-rounding
// stage and the output register. m_axis_tuser flags more than 64 segments, in
// which case m_axis_tdata is all zero.
module lte_code_block_segmentation import lcbs_pkg::*; (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [LCBS_IN_TDATA_W-1:0]  s_axis_tdata,  // [18:0] tb_size
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	// [6:0] num_segments, [13:7] num_plus, [20:14] num_minus,
	// [33:21] size_plus, [46:34] size_minus, [52:47] filler_bits
	output logic [LCBS_OUT_TDATA_W-1:0]      m_axis_tdata,
	output logic                             m_axis_tuser   // [0] status
);

	logic      push, full, pop, empty;
	lcbs_job_t push_job, pop_job;
	lcbs_res_t res;

	lcbs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.tb_size  (s_axis_tdata[LCBS_B_W-1:0]),
		.push     (push),
		.push_job (push_job),
		.full     (full)
	);

	lcbs_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_job),
		.full    (full),
		.pop     (pop),
		.rd_data (pop_job),
		.empty   (empty)
	);

	lcbs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (pop_job),
		.empty     (empty),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tuser = res.status;
	assign m_axis_tdata = {3'b000, res.filler_bits, res.size_minus, res.size_plus,
	                       res.num_minus, res.num_plus, res.num_segments};

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lcbs_pkg::*;

	typedef struct {
		logic [LCBS_B_W-1:0] tb_size;
		lcbs_res_t           res;
	} seg_plan_t;

	typedef struct {
		logic [LCBS_B_W-1:0] tb_size;
		bit                  fixed;
		lcbs_res_t           res;
	} dir_row_t;

	localparam int DIR_N  = 23;
	localparam int RAND_N = 1900;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        s_valid = 1'b0;
	logic [LCBS_IN_TDATA_W-1:0]  s_data = '0;
	logic                        m_ready = 1'b0;
	wire                         s_axis_tready;
	wire                         m_axis_tvalid;
	wire [LCBS_OUT_TDATA_W-1:0]  m_axis_tdata;
	wire                         m_axis_tuser;

	seg_plan_t seg_plans_q[$];
	int        n_fail = 0;

	dir_row_t dir_rows [DIR_N] = '{
		'{19'd0,      1'b1, '{LCBS_STATUS_OK, 7'd1, 7'd1, 7'd0, 13'd40, 13'd0, 6'd40}},
		'{19'd1,      1'b0, '0},
		'{19'd39,     1'b0, '0},
		'{19'd40,     1'b1, '{LCBS_STATUS_OK, 7'd1, 7'd1, 7'd0, 13'd40, 13'd0, 6'd0}},
		'{19'd41,     1'b0, '0},
		'{19'd511,    1'b0, '0},
		'{19'd512,    1'b0, '0},
		'{19'd513,    1'b0, '0},
		'{19'd1024,   1'b0, '0},
		'{19'd1025,   1'b0, '0},
		'{19'd2048,   1'b0, '0},
		'{19'd2049,   1'b0, '0},
		'{19'd6143,   1'b0, '0},
		'{19'd6144,   1'b1, '{LCBS_STATUS_OK, 7'd1, 7'd1, 7'd0, 13'd6144, 13'd0, 6'd0}},
		'{19'd6145,   1'b0, '0},
		'{19'd12240,  1'b0, '0},
		'{19'd12241,  1'b0, '0},
		'{19'h2AAAA,  1'b0, '0},
		'{19'h55555,  1'b0, '0},
		'{19'd195841, 1'b0, '0},
		'{19'd391680, 1'b1, '{LCBS_STATUS_OK, 7'd64, 7'd64, 7'd0, 13'd6144, 13'd6080, 6'd0}},
		'{19'd391681, 1'b1, '{LCBS_STATUS_ERR, 7'd0, 7'd0, 7'd0, 13'd0, 13'd0, 6'd0}},
		'{19'd524287, 1'b1, '{LCBS_STATUS_ERR, 7'd0, 7'd0, 7'd0, 13'd0, 13'd0, 6'd0}}
	};

	lte_code_block_segmentation u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #1 clk = ~clk;

	function automatic int unsigned interleaver_step(input int unsigned k);
		if (k <= 512)
			return 8;
		else if (k <= 1024)
			return 16;
		else if (k <= 2048)
			return 32;
		return 64;
	endfunction

	function automatic lcbs_res_t segment_plan(input logic [LCBS_B_W-1:0] b);
		lcbs_res_t   r;
		int unsigned nseg, bp, q, kp, km, cm, cp, dk;
		r = '0;
		if (b <= LCBS_MAX_BITS) begin
			nseg = 1;
			bp   = b;
		end else begin
			nseg = (b + LCBS_SEG_PAYLOAD - 1) / LCBS_SEG_PAYLOAD;
			bp   = b + nseg * LCBS_CRC_BITS;
		end
		if (nseg > LCBS_MAX_SEGMENTS) begin
			r.status = LCBS_STATUS_ERR;
			return r;
		end
		q = (bp + nseg - 1) / nseg;
		if (q <= LCBS_MIN_SIZE) begin
			kp = LCBS_MIN_SIZE;
		end else begin
			dk = interleaver_step(q);
			kp = ((q + dk - 1) / dk) * dk;
		end
		if (nseg == 1) begin
			km = 0;
			cm = 0;
			cp = 1;
		end else begin
			dk = interleaver_step(kp);
			km = kp - dk;
			cm = (nseg * kp - bp) / dk;
			cp = nseg - cm;
		end
		r.status       = LCBS_STATUS_OK;
		r.num_segments = LCBS_C_W'(nseg);
		r.num_plus     = LCBS_C_W'(cp);
		r.num_minus    = LCBS_C_W'(cm);
		r.size_plus    = LCBS_K_W'(kp);
		r.size_minus   = LCBS_K_W'(km);
		r.filler_bits  = LCBS_F_W'(cp * kp + cm * km - bp);
		return r;
	endfunction

	task automatic check_field(input string fname, input int unsigned want,
		input int unsigned got, input logic [LCBS_B_W-1:0] b);
		if (want != got) begin
			$display("%0t: tb_size %0d %s expected %0d actual %0d", $time, b, fname, want, got);
			n_fail++;
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#1000000;
		$display("simulation failed");
		$finish;
	end

	// sender: bursts of random length, random gaps
	initial begin : stimulus
		int unsigned         burst, gap, k;
		logic [LCBS_B_W-1:0] b;
		lcbs_res_t           res;
		wait (arst_n);
		@(posedge clk);
		burst = 0;
		for (int i = 0; i < DIR_N + RAND_N; i++) begin
			if (i < DIR_N) begin
				b = dir_rows[i].tb_size;
				res = dir_rows[i].fixed ? dir_rows[i].res : segment_plan(b);
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2: b = LCBS_B_W'($urandom_range(0, LCBS_MAX_BITS));
					3:       b = LCBS_B_W'($urandom_range(0, 600));
					4, 5, 6: b = LCBS_B_W'($urandom_range(LCBS_MAX_BITS + 1,
						LCBS_MAX_SEGMENTS * LCBS_SEG_PAYLOAD));
					7: begin
						k = $urandom_range(1, 70) * LCBS_SEG_PAYLOAD + $urandom_range(0, 4);
						b = (k - 2 > 524287) ? 19'h7FFFF : LCBS_B_W'(k - 2);
					end
					8:       b = LCBS_B_W'($urandom_range(LCBS_MAX_SEGMENTS * LCBS_SEG_PAYLOAD + 1,
						524287));
					default: b = LCBS_B_W'($urandom);
				endcase
				res = segment_plan(b);
			end
			if (burst == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap != 0) begin
					s_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst = $urandom_range(1, 40);
			end
			burst--;
			s_valid <= 1'b1;
			s_data  <= LCBS_IN_TDATA_W'(b);
			@(posedge clk);
			while (!s_axis_tready) @(posedge clk);
			seg_plans_q.push_back('{b, res});
		end
		s_valid <= 1'b0;
		while (seg_plans_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (n_fail == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// receiver: stall patterns plus one long hold to back up the pipeline
	initial begin : drain
		int unsigned cyc, mode, len;
		bit          held;
		wait (arst_n);
		@(posedge clk);
		cyc  = 0;
		held = 1'b0;
		forever begin
			if (!held && cyc >= 600) begin
				m_ready <= 1'b0;
				repeat (300) @(posedge clk);
				cyc += 300;
				held = 1'b1;
			end
			mode = $urandom_range(0, 3);
			len  = $urandom_range(10, 120);
			repeat (len) begin
				case (mode)
					0:       m_ready <= 1'b1;
					1:       m_ready <= 1'($urandom_range(0, 1));
					2:       m_ready <= (cyc % 4) != 0;
					default: m_ready <= $urandom_range(0, 7) != 0;
				endcase
				@(posedge clk);
				cyc++;
			end
		end
	end

	seg_plan_t mon_plan;

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_ready) begin
			if (seg_plans_q.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual tdata %h tuser %b",
					$time, m_axis_tdata, m_axis_tuser);
				n_fail++;
			end else begin
				mon_plan = seg_plans_q.pop_front();
				check_field("status", mon_plan.res.status, m_axis_tuser, mon_plan.tb_size);
				check_field("num_segments", mon_plan.res.num_segments, m_axis_tdata[6:0],
					mon_plan.tb_size);
				check_field("num_plus", mon_plan.res.num_plus, m_axis_tdata[13:7],
					mon_plan.tb_size);
				check_field("num_minus", mon_plan.res.num_minus, m_axis_tdata[20:14],
					mon_plan.tb_size);
				check_field("size_plus", mon_plan.res.size_plus, m_axis_tdata[33:21],
					mon_plan.tb_size);
				check_field("size_minus", mon_plan.res.size_minus, m_axis_tdata[46:34],
					mon_plan.tb_size);
				check_field("filler_bits", mon_plan.res.filler_bits, m_axis_tdata[52:47],
					mon_plan.tb_size);
			end
		end
	end

endmodule

`default_nettype wire
